[rtl/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// Direct-mapped read cache package
// Shared widths, defaults, command and register codes, and beat types.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Default geometry. All three must be powers of two.
  localparam int unsigned DefMemoryBytes = 4096;
  localparam int unsigned DefLineBytes   = 16;
  localparam int unsigned DefLineCount   = 8;

  localparam int unsigned AddrW      = 12;
  localparam int unsigned DataW      = 8;
  localparam int unsigned CountW     = 32;
  localparam int unsigned TagW       = 8;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned QueueDepth = 2;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRead  = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgHitCost     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMissPenalty = 1'b1;

  localparam logic [DataW-1:0] HitCostReset     = 8'd1;
  localparam logic [DataW-1:0] MissPenaltyReset = 8'd20;

  typedef struct packed {
    logic             command;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } dmc_in_t;

  typedef struct packed {
    logic              hit;
    logic [DataW-1:0]  read_data;
    logic [CountW-1:0] access_total;
    logic [CountW-1:0] miss_total;
    logic [CountW-1:0] time_total;
  } dmc_out_t;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic    hit;
    dmc_in_t item;
  } dmc_req_t;

  typedef struct packed {
    logic [DataW-1:0] hit_cost;
    logic [DataW-1:0] miss_penalty;
  } dmc_cost_t;

endpackage

[rtl/dmc_front.sv]
// ----------------------------------------------------------------------------
// Direct-mapped read cache front end
// Accepts beats, looks up the tag store and classifies each read as hit or miss.
// ----------------------------------------------------------------------------
module dmc_front import dmc_pkg::*; #(
  parameter int unsigned MemoryBytes = DefMemoryBytes,
  parameter int unsigned LineBytes   = DefLineBytes,
  parameter int unsigned LineCount   = DefLineCount
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dmc_in_t  in_data_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output dmc_req_t push_data_o
);

  localparam int unsigned MemAw = $clog2(MemoryBytes);
  localparam int unsigned OffW  = $clog2(LineBytes);
  localparam int unsigned IdxW  = $clog2(LineCount);

  logic                 s_valid_q, s_valid_d;
  dmc_in_t              s_item_q;
  logic [TagW-1:0]      tag_rdata_q;
  logic [TagW-1:0]      tag_mem [LineCount];
  logic [LineCount-1:0] line_valid_q, line_valid_d;

  logic             accept, push, fill_claim, s_hit;
  logic [MemAw-1:0] in_wrap, s_wrap;
  logic [IdxW-1:0]  in_line, s_line;
  logic [TagW-1:0]  s_tag;

  // One item at a time: the tag store is updated in the classify cycle,
  // before the next lookup is issued.
  assign in_ready_o = !s_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_wrap = MemAw'(in_data_i.address);
    in_line = IdxW'(in_wrap >> OffW);
    s_wrap  = MemAw'(s_item_q.address);
    s_line  = IdxW'(s_wrap >> OffW);
    s_tag   = TagW'(s_wrap >> (OffW + IdxW));
    s_hit   = line_valid_q[s_line] && (tag_rdata_q == s_tag);
  end

  assign push       = s_valid_q && push_ready_i;
  assign fill_claim = push && (s_item_q.command == CmdRead) && !s_hit;

  assign push_valid_o = s_valid_q;
  assign push_data_o  = '{hit: s_hit, item: s_item_q};

  always_comb begin
    s_valid_d = s_valid_q;
    if (accept) begin
      s_valid_d = 1'b1;
    end else if (push) begin
      s_valid_d = 1'b0;
    end
    line_valid_d = line_valid_q;
    if (fill_claim) begin
      line_valid_d[s_line] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q    <= 1'b0;
      line_valid_q <= '0;
    end else begin
      s_valid_q    <= s_valid_d;
      line_valid_q <= line_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_item_q    <= in_data_i;
      tag_rdata_q <= tag_mem[in_line];
    end
    if (fill_claim) begin
      tag_mem[s_line] <= s_tag;
    end
  end

  // A miss that leaves for the back end owns its line from the next cycle on.
  a_fill_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_claim |=> line_valid_q[$past(s_line)])
    else $error("line not marked valid after a miss was issued");

endmodule

[rtl/dmc_fifo.sv]
// ----------------------------------------------------------------------------
// Direct-mapped read cache request queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dmc_fifo import dmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  dmc_req_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output dmc_req_t pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  dmc_req_t        entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("request queue holds more entries than it has");

endmodule

[rtl/dmc_back.sv]
// ----------------------------------------------------------------------------
// Direct-mapped read cache back end
// Writes backing memory, fills lines on a miss, reads the cache data store
// and keeps the saturating access, miss and time counters.
// ----------------------------------------------------------------------------
module dmc_back import dmc_pkg::*; #(
  parameter int unsigned MemoryBytes = DefMemoryBytes,
  parameter int unsigned LineBytes   = DefLineBytes,
  parameter int unsigned LineCount   = DefLineCount
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dmc_cost_t cost_i,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  dmc_req_t  pop_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dmc_out_t  out_data_o
);

  localparam int unsigned MemAw = $clog2(MemoryBytes);
  localparam int unsigned OffW  = $clog2(LineBytes);
  localparam int unsigned IdxW  = $clog2(LineCount);
  localparam int unsigned DmAw  = OffW + IdxW;
  localparam int unsigned CntW  = OffW + 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFill  = 2'd1;
  localparam logic [1:0] StIssue = 2'd2;
  localparam logic [1:0] StData  = 2'd3;

  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                input logic [CountW-1:0] b);
    logic [CountW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CountW] ? '1 : sum[CountW-1:0];
  endfunction

  logic [DataW-1:0] bm_mem [MemoryBytes];
  logic [DataW-1:0] dm_mem [LineCount * LineBytes];
  logic [DataW-1:0] bm_rdata_q, dm_rdata_q;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  dmc_req_t          req_q;
  logic              out_valid_q, out_valid_d;
  dmc_out_t          out_data_q;
  logic [CountW-1:0] access_q, access_d, miss_q, miss_d, time_q, time_d;

  logic             pop, out_load, out_free;
  logic             bm_we, bm_re, dm_we, dm_re;
  logic [MemAw-1:0] pop_wrap, req_wrap, bm_raddr;
  logic [DmAw-1:0]  pop_daddr, req_daddr, dm_raddr, dm_waddr;
  logic [IdxW-1:0]  req_line;

  always_comb begin
    pop_wrap  = MemAw'(pop_data_i.item.address);
    pop_daddr = {IdxW'(pop_wrap >> OffW), OffW'(pop_wrap)};
    req_wrap  = MemAw'(req_q.item.address);
    req_line  = IdxW'(req_wrap >> OffW);
    req_daddr = {req_line, OffW'(req_wrap)};
    bm_raddr  = {req_wrap[MemAw-1:OffW], OffW'(cnt_q)};
    dm_waddr  = {req_line, OffW'(cnt_q - 1'b1)};
    dm_raddr  = (state_q == StIdle) ? pop_daddr : req_daddr;
  end

  assign pop_ready_o = (state_q == StIdle);
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    bm_we    = 1'b0;
    bm_re    = 1'b0;
    dm_we    = 1'b0;
    dm_re    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (pop) begin
          if (pop_data_i.item.command == CmdWrite) begin
            bm_we = 1'b1;
          end else if (pop_data_i.hit) begin
            dm_re   = 1'b1;
            state_d = StData;
          end else begin
            cnt_d   = '0;
            state_d = StFill;
          end
        end
      end
      StFill: begin
        // Read byte cnt from backing memory, write byte cnt-1 into the line.
        bm_re = !cnt_q[OffW];
        dm_we = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(LineBytes)) begin
          state_d = StIssue;
        end
      end
      StIssue: begin
        dm_re   = 1'b1;
        state_d = StData;
      end
      StData: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    access_d = access_q;
    miss_d   = miss_q;
    time_d   = time_q;
    if (out_load) begin
      access_d = sat_add(access_q, CountW'(1));
      if (req_q.hit) begin
        time_d = sat_add(time_q, CountW'(cost_i.hit_cost));
      end else begin
        miss_d = sat_add(miss_q, CountW'(1));
        time_d = sat_add(time_q, CountW'(cost_i.miss_penalty));
      end
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      access_q    <= '0;
      miss_q      <= '0;
      time_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      access_q    <= access_d;
      miss_q      <= miss_d;
      time_q      <= time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      req_q <= pop_data_i;
    end
    if (out_load) begin
      out_data_q <= '{hit: req_q.hit, read_data: dm_rdata_q, access_total: access_d,
                      miss_total: miss_d, time_total: time_d};
    end
  end

  // Backing memory: written by write commands, read during line fills.
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[pop_wrap] <= pop_data_i.item.write_data;
    end
    if (bm_re) begin
      bm_rdata_q <= bm_mem[bm_raddr];
    end
  end

  // Cache data store: written during fills, read once per read access.
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= bm_rdata_q;
    end
    if (dm_re) begin
      dm_rdata_q <= dm_mem[dm_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_fill_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill) |-> (req_q.item.command == CmdRead) && !req_q.hit)
    else $error("line fill running for a request that is not a read miss");

  a_bm_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bm_we && bm_re))
    else $error("backing memory written and read in the same cycle");

  a_misses_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.miss_total <= out_data_q.access_total))
    else $error("miss total exceeds access total");

endmodule

[rtl/direct_mapped_read_cache.sv]
// ----------------------------------------------------------------------------
// Direct-mapped read cache
// LineCount lines of LineBytes bytes in front of a byte-wide backing memory.
// ----------------------------------------------------------------------------
// Usage: requests enter on the in channel (valid/ready). A write command stores
// write_data into backing memory and produces no result beat. A read command
// produces exactly one result beat on the out channel with the hit flag, the
// byte read and the saturating access, miss and time totals after this access.
// Backing memory must be written before a line fill reads it.
// A read is registered in the front end, in the queue, in the data store read
// register and in the output register; a read miss first fills its line.
// The front end holds one beat at a time and takes no new one until the last
// has left for the queue, since the tag store is looked up when a beat is
// accepted and updated when a read miss leaves. The back end takes no new
// request until the last is done; a line fill moves one byte per cycle
// through the single read port of the backing memory. A two-entry queue
// lets the front end run ahead of a fill.
// Reset clears the line valid bits, the counters and the queue and restores
// hit_cost to 1 and miss_penalty to 20; backing memory keeps no reset value.
// When the receiver stalls, the result beat waits in the output register, the
// back end holds the next read and the queue fills before in_ready_o drops.
// The configuration port writes hit_cost (index 0) or miss_penalty (index 1)
// and must only be used while the block is idle.
// ----------------------------------------------------------------------------
module direct_mapped_read_cache import dmc_pkg::*; #(
  parameter int unsigned MemoryBytes = DefMemoryBytes,
  parameter int unsigned LineBytes   = DefLineBytes,
  parameter int unsigned LineCount   = DefLineCount
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dmc_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dmc_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i
);

  // Cost registers used by the back end when it totals the access time.
  dmc_cost_t cost_q, cost_d;

  always_comb begin
    cost_d = cost_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHitCost:     cost_d.hit_cost     = cfg_wdata_i;
        CfgMissPenalty: cost_d.miss_penalty = cfg_wdata_i;
        default:        cost_d              = cost_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= '{hit_cost: HitCostReset, miss_penalty: MissPenaltyReset};
    end else begin
      cost_q <= cost_d;
    end
  end

  // Front end -> queue -> back end.
  logic     push_valid, push_ready, pop_valid, pop_ready;
  dmc_req_t push_data, pop_data;

  dmc_front #(
    .MemoryBytes (MemoryBytes),
    .LineBytes   (LineBytes),
    .LineCount   (LineCount)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  dmc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dmc_back #(
    .MemoryBytes (MemoryBytes),
    .LineBytes   (LineBytes),
    .LineCount   (LineCount)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cost_i      (cost_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[dv/tb_direct_mapped_read_cache.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Direct-mapped read cache testbench
// Sends write and read beats with random gaps and checks every result beat
// against an in-bench prediction of the cache, its line fills and its totals.
// ----------------------------------------------------------------------------
module tb_direct_mapped_read_cache;
  import dmc_pkg::*;

  // A miss takes the longest of all requests, and writes may still sit in the
  // request queue behind the last read, so the settle pause covers the tail.
  localparam int SettleCycles  = 40;
  // Cycles without any accepted beat before the run is declared hung. The
  // longest legal stretch is a settle pause or a stalled miss, far below this.
  localparam int WatchdogLimit = 2000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  dmc_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  dmc_out_t           out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [DataW-1:0]   cfg_wdata_i = '0;

  direct_mapped_read_cache DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predicted cache state. It follows the block beat by beat in the order the
  // beats are accepted, so the costs only change while the block is idle.
  // --------------------------------------------------------------------------
  logic [4:0]        line_tag   [8];
  logic              line_valid [8];
  logic [DataW-1:0]  line_data  [128];
  logic [DataW-1:0]  backing    [4096];
  logic [CountW-1:0] access_cnt;
  logic [CountW-1:0] miss_cnt;
  logic [CountW-1:0] time_cnt;
  logic [DataW-1:0]  cost_hit;
  logic [DataW-1:0]  cost_miss;

  dmc_out_t expected_reads[$];

  // Stimulus bookkeeping. A line may only be read once all 16 of its bytes
  // have been written, because a miss copies the whole line from backing
  // memory and unwritten bytes have no defined value.
  dmc_in_t     pending_beats[$];
  bit          byte_written [4096];
  bit          line_loaded  [256];
  logic [7:0]  loaded_lines[$];
  logic [7:0]  last_read_line;

  // Shared between the stimulus thread and the clocked blocks.
  bit          no_idle = 1'b0;
  int          mismatch_count = 0;

  // Handshake history, registered at the rising edge for the falling-edge
  // driver and receiver.
  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  int          send_gap  = 0;
  int          recv_stall = 0;
  int          quiet_cycles = 0;
  dmc_out_t    oldest_read;

  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                input logic [CountW-1:0] b);
    logic [CountW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CountW] ? '1 : sum[CountW-1:0];
  endfunction

  // Applies one accepted beat to the predicted state. A write only lands in
  // backing memory, so a cached copy of that byte goes stale on purpose. A
  // read yields the expected result beat.
  task automatic compute_cache_read(input dmc_in_t req);
    logic [3:0] ofs;
    logic [2:0] idx;
    logic [4:0] tg;
    dmc_out_t   res;
    int         j;
    ofs = req.address[3:0];
    idx = req.address[6:4];
    tg  = req.address[11:7];
    if (req.command == CmdWrite) begin
      backing[req.address] = req.write_data;
    end else begin
      access_cnt = sat_add(access_cnt, 1);
      if (line_valid[idx] && line_tag[idx] == tg) begin
        res.hit  = 1'b1;
        time_cnt = sat_add(time_cnt, {24'd0, cost_hit});
      end else begin
        // The reset tags never match because the valid bits start cleared.
        res.hit  = 1'b0;
        miss_cnt = sat_add(miss_cnt, 1);
        time_cnt = sat_add(time_cnt, {24'd0, cost_miss});
        line_tag[idx]   = tg;
        line_valid[idx] = 1'b1;
        for (j = 0; j < 16; j++) begin
          line_data[{idx, j[3:0]}] = backing[{req.address[11:4], j[3:0]}];
        end
      end
      res.read_data    = line_data[{idx, ofs}];
      res.access_total = access_cnt;
      res.miss_total   = miss_cnt;
      res.time_total   = time_cnt;
      expected_reads.push_back(res);
    end
  endtask

  task automatic check_field(input string field, input logic [CountW-1:0] want,
                             input logic [CountW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor. Outputs are sampled at the rising edge. A result beat is checked
  // before the request beat of the same edge is predicted, so a stray result
  // can never be matched against a read that was only just accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_taken  <= in_valid_i && in_ready_o;
    out_taken <= out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: result beat with no read pending, actual %0h", $time, out_data_o);
          mismatch_count++;
        end else begin
          oldest_read = expected_reads.pop_front();
          check_field("hit", CountW'(oldest_read.hit), CountW'(out_data_o.hit));
          check_field("read_data", CountW'(oldest_read.read_data),
                      CountW'(out_data_o.read_data));
          check_field("access_total", oldest_read.access_total, out_data_o.access_total);
          check_field("miss_total", oldest_read.miss_total, out_data_o.miss_total);
          check_field("time_total", oldest_read.time_total, out_data_o.time_total);
        end
      end
      if (in_valid_i && in_ready_o) begin
        compute_cache_read(in_data_i);
      end
      // The watchdog restarts on any accepted beat in either direction.
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, WatchdogLimit);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver. Runs at the falling edge. A presented beat is held until the edge
  // that accepts it; then a random gap, none while no_idle is set, is drawn for the next one.
  // Valid is assigned once per edge, so back-to-back beats keep it high.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && !in_taken)) begin
        if (in_valid_i) begin
          send_gap = no_idle ? 0 : $urandom_range(0, 8);
        end
        if (send_gap == 0 && pending_beats.size() != 0) begin
          in_data_i  <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          if (send_gap != 0) begin
            send_gap = send_gap - 1;
          end
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. After each accepted result it draws a random stall, none while no_idle is set.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        recv_stall = no_idle ? 0 : $urandom_range(0, 8);
      end else if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
      end
      out_ready_i <= (recv_stall == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_write(input logic [11:0] addr, input logic [7:0] data);
    dmc_in_t    beat;
    logic [7:0] ln;
    bit         full;
    int         j;
    beat.command    = CmdWrite;
    beat.address    = addr;
    beat.write_data = data;
    pending_beats.push_back(beat);
    byte_written[addr] = 1'b1;
    ln = addr[11:4];
    if (!line_loaded[ln]) begin
      full = 1'b1;
      for (j = 0; j < 16; j++) begin
        if (!byte_written[{ln, j[3:0]}]) full = 1'b0;
      end
      if (full) begin
        line_loaded[ln] = 1'b1;
        loaded_lines.push_back(ln);
      end
    end
  endtask

  // The write_data field is ignored on reads but still toggled at random.
  task automatic push_read(input logic [11:0] addr);
    dmc_in_t beat;
    beat.command    = CmdRead;
    beat.address    = addr;
    beat.write_data = 8'($urandom_range(0, 255));
    pending_beats.push_back(beat);
  endtask

  // Mostly reads of loaded lines, with half of them returning to the line
  // read last so that hits are common, while picks from all loaded lines
  // give conflict misses. Whole-line loads grow the readable set, and some
  // writes land on lines that may be cached, which leaves stale copies.
  task automatic queue_random_items(input int count);
    int         made;
    int         pick;
    int         j;
    logic [7:0] ln;
    logic [3:0] ofs;
    logic [7:0] data;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (loaded_lines.size() < 3 || pick < 4) begin
        ln = 8'($urandom_range(0, 255));
        for (j = 0; j < 16; j++) begin
          data = 8'($urandom_range(0, 255));
          push_write({ln, j[3:0]}, data);
        end
        made += 16;
      end else if (pick < 14) begin
        data = 8'($urandom_range(0, 255));
        push_write(12'($urandom_range(0, 4095)), data);
        made++;
      end else if (pick < 24) begin
        ln   = loaded_lines[$urandom_range(0, loaded_lines.size() - 1)];
        ofs  = 4'($urandom_range(0, 15));
        data = 8'($urandom_range(0, 255));
        push_write({ln, ofs}, data);
        made++;
      end else begin
        if (pick < 62) begin
          last_read_line = loaded_lines[$urandom_range(0, loaded_lines.size() - 1)];
        end
        ofs = 4'($urandom_range(0, 15));
        push_read({last_read_line, ofs});
        made++;
      end
    end
  endtask

  // Holds the sender until every queued beat is accepted and every expected
  // result has come back, then lets trailing writes drain.
  task automatic wait_for_quiet();
    while (pending_beats.size() != 0 || in_valid_i || expected_reads.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes both cost registers while the block is idle and mirrors them.
  task automatic set_costs(input logic [7:0] hit_val, input logic [7:0] miss_val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgHitCost;
    cfg_wdata_i <= hit_val;
    @(negedge clk_i);
    cfg_idx_i   <= CfgMissPenalty;
    cfg_wdata_i <= miss_val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cost_hit  = hit_val;
    cost_miss = miss_val;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int         i;
    int         phase;
    logic [7:0] data;

    for (i = 0; i < 8; i++) begin
      line_tag[i]   = 5'h1F;
      line_valid[i] = 1'b0;
    end
    for (i = 0; i < 128; i++) line_data[i] = 8'h23;
    for (i = 0; i < 4096; i++) backing[i] = '0;
    access_cnt = '0;
    miss_cnt   = '0;
    time_cnt   = '0;
    cost_hit   = HitCostReset;
    cost_miss  = MissPenaltyReset;

    // Directed part, with the reset costs. The top line of memory is loaded
    // with both data extremes at its ends, and the first read of it must miss
    // since no line has ever been filled.
    for (i = 0; i < 16; i++) begin
      data = (i == 0) ? 8'h00 : (i == 15) ? 8'hFF : 8'($urandom_range(0, 255));
      push_write({8'hFF, i[3:0]}, data);
    end
    push_read(12'hFFF);
    push_read(12'hFF0);
    // Overwriting a cached byte reaches backing memory only, so the next hit
    // still returns the byte that was there at fill time.
    push_write(12'hFF0, 8'h5A);
    push_read(12'hFF0);
    push_write(12'h000, 8'hFF);
    push_read(12'hFF7);
    last_read_line = 8'hFF;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Random phases. Each one starts from an idle block with new costs; the
    // first runs without any gaps or stalls.
    for (phase = 0; phase < 5; phase++) begin
      wait_for_quiet();
      case (phase)
        0: begin
          set_costs(8'd0, 8'd0);
          no_idle = 1'b1;
        end
        1: begin
          set_costs(8'd255, 8'd255);
          no_idle = 1'b0;
        end
        3: set_costs(HitCostReset, MissPenaltyReset);
        default: set_costs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      queue_random_items(76);
    end

    wait_for_quiet();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dmc_pkg.sv
rtl/dmc_front.sv
rtl/dmc_fifo.sv
rtl/dmc_back.sv
rtl/direct_mapped_read_cache.sv
dv/tb_direct_mapped_read_cache.sv
